// ----- rtl/core/i2cm_pkg.sv -----
// shared types, command codes and a helper function for the i2c master byte engine
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam logic [2:0] CMD_IDLE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_STOP    = 3'd2;
    localparam logic [2:0] CMD_WRITE   = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;
    localparam logic [2:0] CMD_RECOVER = 3'd5;

    localparam logic [3:0] RECOVER_PULSES = 4'd9;
    localparam logic [4:0] PHASE_LAST     = 5'd31;

    typedef struct packed {
        logic [2:0] cmd;
        logic [4:0] phase;
        logic [3:0] bit_cnt;
        logic [7:0] shift;
        logic       ack_to_send;
        logic       ack_seen;
        logic [3:0] pulse_cnt;
        logic       scl;
        logic       sda;
        logic       free_flag;
        logic [7:0] rx_hold;
    } i2cm_state_t;

    // idle, both lines released, everything else cleared
    localparam i2cm_state_t STATE_RESET = {CMD_IDLE, 5'd0, 4'd0, 8'd0, 1'b0, 1'b0, 4'd0,
                                           1'b1, 1'b1, 1'b0, 8'd0};

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       acked;
        logic       bus_free;
    } i2cm_result_t;

    // phase modulo 3 for phases below 24, via reciprocal multiply
    function automatic logic [1:0] mod3_phase(input logic [4:0] p);
        logic [8:0] prod;
        logic [3:0] quo;
        logic [5:0] three_q;
        logic [5:0] rem;
        begin
            prod    = {4'd0, p} * 9'd11;
            quo     = prod[8:5];
            three_q = {2'd0, quo} + {1'b0, quo, 1'b0};
            rem     = {1'b0, p} - three_q;
            mod3_phase = rem[1:0];
        end
    endfunction

endpackage

// ----- rtl/core/i2cm_step.sv -----
// next-state and result logic for one bus tick
`timescale 1ns / 1ps

module i2cm_step
    import i2cm_pkg::*;
(
    input  i2cm_state_t  st,
    input  logic [2:0]   op,
    input  logic [7:0]   tx_byte,
    input  logic         send_ack,
    input  logic         sda_in,
    output i2cm_state_t  st_next,
    output i2cm_result_t res
);

    always_comb
    begin
        i2cm_state_t n;
        logic [4:0]  p;
        logic        busy;
        logic        done;
        n    = st;
        busy = 1'b0;
        done = 1'b0;

        if (st.cmd == CMD_IDLE && op >= CMD_START && op <= CMD_RECOVER)
        begin
            n.cmd     = op;
            n.phase   = 5'd0;
            n.bit_cnt = 4'd0;
            if (op == CMD_WRITE)
            begin
                n.shift = tx_byte;
            end
            if (op == CMD_READ)
            begin
                n.ack_to_send = send_ack;
            end
        end

        p = n.phase;
        if (n.cmd != CMD_IDLE)
        begin
            busy = 1'b1;
            unique case (n.cmd)
                CMD_START:
                begin
                    if (p == 5'd0)      n.sda = 1'b1;
                    else if (p == 5'd1) n.scl = 1'b1;
                    else if (p == 5'd2) n.sda = 1'b0;
                    else
                    begin
                        n.scl = 1'b0;
                        done  = 1'b1;
                    end
                end
                CMD_STOP:
                begin
                    if (p == 5'd0)      n.sda = 1'b0;
                    else if (p == 5'd1) n.scl = 1'b1;
                    else
                    begin
                        n.sda = 1'b1;
                        done  = 1'b1;
                    end
                end
                CMD_WRITE:
                begin
                    if (p < 5'd24)
                    begin
                        case (mod3_phase(p))
                            2'd0:    n.sda = n.shift[7];
                            2'd1:    n.scl = 1'b1;
                            default:
                            begin
                                n.scl     = 1'b0;
                                n.shift   = {n.shift[6:0], 1'b0};
                                n.bit_cnt = n.bit_cnt + 4'd1;
                            end
                        endcase
                    end
                    else if (p == 5'd24) n.sda = 1'b1;
                    else if (p == 5'd25) n.scl = 1'b1;
                    else
                    begin
                        n.ack_seen = ~sda_in;
                        n.scl      = 1'b0;
                        done       = 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (p == 5'd0)
                    begin
                        n.sda     = 1'b1;
                        n.shift   = 8'd0;
                        n.bit_cnt = 4'd0;
                    end
                    else if (p <= 5'd16)
                    begin
                        if (p[0])
                        begin
                            n.scl = 1'b1;
                        end
                        else
                        begin
                            n.shift   = {n.shift[6:0], sda_in};
                            n.bit_cnt = n.bit_cnt + 4'd1;
                            n.scl     = 1'b0;
                        end
                    end
                    else if (p == 5'd17) n.sda = ~n.ack_to_send;
                    else if (p == 5'd18) n.scl = 1'b1;
                    else if (p == 5'd19) n.scl = 1'b0;
                    else
                    begin
                        n.sda     = 1'b1;
                        n.rx_hold = n.shift;
                        done      = 1'b1;
                    end
                end
                CMD_RECOVER:
                begin
                    if (p == 5'd0)
                    begin
                        n.sda       = 1'b1;
                        n.pulse_cnt = 4'd0;
                    end
                    else if (p == 5'd1)
                    begin
                        if (!sda_in && n.pulse_cnt < RECOVER_PULSES)
                        begin
                            n.scl = 1'b0;
                        end
                        else
                        begin
                            n.sda = 1'b0;
                            p     = 5'd2;
                        end
                    end
                    else if (p == 5'd2)
                    begin
                        n.scl       = 1'b1;
                        n.pulse_cnt = n.pulse_cnt + 4'd1;
                        p           = 5'd0;
                    end
                    else if (p == 5'd3) n.scl = 1'b1;
                    else if (p == 5'd4) n.sda = 1'b1;
                    else
                    begin
                        n.free_flag = sda_in;
                        done        = 1'b1;
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
            if (!done && p >= PHASE_LAST)
            begin
                done = 1'b1;
            end
            if (done)
            begin
                n.cmd   = CMD_IDLE;
                n.phase = 5'd0;
            end
            else
            begin
                n.phase = p + 5'd1;
            end
        end

        st_next      = n;
        res.scl      = n.scl;
        res.sda      = n.sda;
        res.busy     = busy;
        res.done     = done;
        res.rx_byte  = n.rx_hold;
        res.acked    = n.ack_seen;
        res.bus_free = n.free_flag;
    end

endmodule

// ----- rtl/core/i2cm_out_stage.sv -----
// result register between the tick logic and the output stream
`timescale 1ns / 1ps

module i2cm_out_stage
    import i2cm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  i2cm_result_t res_in,
    output logic         ready,
    output logic         valid,
    input  logic         take,
    output i2cm_result_t res_out
);

    logic         valid_reg;
    logic         valid_next;
    i2cm_result_t res_reg;

    assign ready      = !valid_reg || take;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign valid   = valid_reg;
    assign res_out = res_reg;

endmodule

// ----- rtl/core/i2c_master_byte_engine.sv -----
// top level of the i2c master byte engine: tick state register and stream ports
//
// channel   dir  tdata                                             tuser  tlast
// s_axis    in   tx_byte, send_ack, sda_in                         op     -
// m_axis    out  scl_out, sda_out, busy_res, rx_byte, acked, free  -      done_res
//
// one tick per cycle unless the output stalls, one result per tick, registered result
// the tick state register and the result register update on every input transfer
// reset releases both lines and leaves the engine idle
// a stalled output holds its result and blocks input transfers only while full
`timescale 1ns / 1ps

module i2c_master_byte_engine
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // tx_byte[7:0], send_ack[8], sda_in[9], zero fill
    input  logic [2:0]  s_axis_tuser,   // op[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // scl_out[0], sda_out[1], busy_res[2], rx_byte[10:3],
                                        // acked[11], bus_free[12], zero fill
    output logic        m_axis_tlast    // done_res
);

    i2cm_state_t  state_reg;
    i2cm_state_t  state_next;
    i2cm_result_t res_comb;
    i2cm_result_t res_q;
    logic         s_accept;

    assign s_accept = s_axis_tvalid && s_axis_tready;

    i2cm_step u_step (
        .st       (state_reg),
        .op       (s_axis_tuser),
        .tx_byte  (s_axis_tdata[7:0]),
        .send_ack (s_axis_tdata[8]),
        .sda_in   (s_axis_tdata[9]),
        .st_next  (state_next),
        .res      (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (s_accept)
        begin
            state_reg <= state_next;
        end
    end

    i2cm_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (s_accept),
        .res_in  (res_comb),
        .ready   (s_axis_tready),
        .valid   (m_axis_tvalid),
        .take    (m_axis_tready),
        .res_out (res_q)
    );

    assign m_axis_tdata = {3'd0, res_q.bus_free, res_q.acked, res_q.rx_byte,
                           res_q.busy, res_q.sda, res_q.scl};
    assign m_axis_tlast = res_q.done;

`ifndef SYNTHESIS
    a_done_busy : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[2])
        else $error("done without busy");

    a_idle_phase : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cmd == CMD_IDLE |-> state_reg.phase == 5'd0)
        else $error("idle with nonzero phase");

    a_cmd_busy : assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && state_reg.cmd == CMD_IDLE &&
        (s_axis_tuser == CMD_START || s_axis_tuser == CMD_STOP ||
         s_axis_tuser == CMD_WRITE || s_axis_tuser == CMD_READ ||
         s_axis_tuser == CMD_RECOVER)
        |=> m_axis_tvalid && m_axis_tdata[2])
        else $error("command not started");
`endif

endmodule

// ----- bench/i2cm_line_checker.sv -----
// checker for the i2c master byte engine: tick predictor and result comparison
`timescale 1ns / 1ps

module i2cm_line_checker
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // tx_byte[7:0], send_ack[8], sda_in[9], zero fill
    input  logic [2:0]  s_axis_tuser,   // op[2:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // scl_out[0], sda_out[1], busy_res[2], rx_byte[10:3],
                                        // acked[11], bus_free[12], zero fill
    input  logic        m_axis_tlast,   // done_res
    output int          mismatch_count,
    output int          tick_backlog
);

    i2cm_state_t  eng;
    i2cm_result_t line_q[$];

    function automatic i2cm_result_t engine_tick(input logic [2:0] op, input logic [7:0] tx,
                                                 input logic ack, input logic sd);
        logic [4:0]   p;
        logic         busy;
        logic         done;
        int           sub;
        i2cm_result_t r;
        busy = 1'b0;
        done = 1'b0;
        if (eng.cmd == CMD_IDLE && op >= CMD_START && op <= CMD_RECOVER)
        begin
            eng.cmd     = op;
            eng.phase   = '0;
            eng.bit_cnt = '0;
            if (op == CMD_WRITE)
                eng.shift = tx;
            if (op == CMD_READ)
                eng.ack_to_send = ack;
        end
        p = eng.phase;
        if (eng.cmd != CMD_IDLE)
        begin
            busy = 1'b1;
            case (eng.cmd)
                CMD_START:
                begin
                    if (p == 5'd0)
                        eng.sda = 1'b1;
                    else if (p == 5'd1)
                        eng.scl = 1'b1;
                    else if (p == 5'd2)
                        eng.sda = 1'b0;
                    else
                    begin
                        eng.scl = 1'b0;
                        done    = 1'b1;
                    end
                end
                CMD_STOP:
                begin
                    if (p == 5'd0)
                        eng.sda = 1'b0;
                    else if (p == 5'd1)
                        eng.scl = 1'b1;
                    else
                    begin
                        eng.sda = 1'b1;
                        done    = 1'b1;
                    end
                end
                CMD_WRITE:
                begin
                    if (p < 5'd24)
                    begin
                        sub = p % 3;
                        if (sub == 0)
                            eng.sda = eng.shift[7];
                        else if (sub == 1)
                            eng.scl = 1'b1;
                        else
                        begin
                            eng.scl     = 1'b0;
                            eng.shift   = {eng.shift[6:0], 1'b0};
                            eng.bit_cnt = eng.bit_cnt + 4'd1;
                        end
                    end
                    else if (p == 5'd24)
                        eng.sda = 1'b1;
                    else if (p == 5'd25)
                        eng.scl = 1'b1;
                    else
                    begin
                        eng.ack_seen = !sd;
                        eng.scl      = 1'b0;
                        done         = 1'b1;
                    end
                end
                CMD_READ:
                begin
                    if (p == 5'd0)
                    begin
                        eng.sda     = 1'b1;
                        eng.shift   = '0;
                        eng.bit_cnt = '0;
                    end
                    else if (p <= 5'd16)
                    begin
                        if (p[0])
                            eng.scl = 1'b1;
                        else
                        begin
                            eng.shift   = {eng.shift[6:0], sd};
                            eng.bit_cnt = eng.bit_cnt + 4'd1;
                            eng.scl     = 1'b0;
                        end
                    end
                    else if (p == 5'd17)
                        eng.sda = !eng.ack_to_send;
                    else if (p == 5'd18)
                        eng.scl = 1'b1;
                    else if (p == 5'd19)
                        eng.scl = 1'b0;
                    else
                    begin
                        eng.sda     = 1'b1;
                        eng.rx_hold = eng.shift;
                        done        = 1'b1;
                    end
                end
                CMD_RECOVER:
                begin
                    if (p == 5'd0)
                    begin
                        eng.sda       = 1'b1;
                        eng.pulse_cnt = '0;
                    end
                    else if (p == 5'd1)
                    begin
                        if (!sd && eng.pulse_cnt < RECOVER_PULSES)
                            eng.scl = 1'b0;
                        else
                        begin
                            // bus released or pulses used up: go to the stop
                            eng.sda = 1'b0;
                            p       = 5'd2;
                        end
                    end
                    else if (p == 5'd2)
                    begin
                        eng.scl       = 1'b1;
                        eng.pulse_cnt = eng.pulse_cnt + 4'd1;
                        p             = 5'd0;
                    end
                    else if (p == 5'd3)
                        eng.scl = 1'b1;
                    else if (p == 5'd4)
                        eng.sda = 1'b1;
                    else
                    begin
                        eng.free_flag = sd;
                        done          = 1'b1;
                    end
                end
                default:
                    done = 1'b1;
            endcase
            if (!done && p == PHASE_LAST)
                done = 1'b1;
            if (done)
            begin
                eng.cmd   = CMD_IDLE;
                eng.phase = '0;
            end
            else
                eng.phase = p + 5'd1;
        end
        r.scl      = eng.scl;
        r.sda      = eng.sda;
        r.busy     = busy;
        r.done     = done;
        r.rx_byte  = eng.rx_hold;
        r.acked    = eng.ack_seen;
        r.bus_free = eng.free_flag;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        i2cm_result_t got;
        i2cm_result_t want;
        if (!rst_n)
        begin
            eng           = '0;
            eng.scl       = 1'b1;
            eng.sda       = 1'b1;
            line_q.delete();
            mismatch_count = 0;
            tick_backlog   = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.scl      = m_axis_tdata[0];
                got.sda      = m_axis_tdata[1];
                got.busy     = m_axis_tdata[2];
                got.rx_byte  = m_axis_tdata[10:3];
                got.acked    = m_axis_tdata[11];
                got.bus_free = m_axis_tdata[12];
                got.done     = m_axis_tlast;
                if (line_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with none pending, expected none, actual %0h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want = line_q.pop_front();
                    check_field("scl_out", 8'(got.scl), 8'(want.scl));
                    check_field("sda_out", 8'(got.sda), 8'(want.sda));
                    check_field("busy_res", 8'(got.busy), 8'(want.busy));
                    check_field("done_res", 8'(got.done), 8'(want.done));
                    check_field("rx_byte", got.rx_byte, want.rx_byte);
                    check_field("acked", 8'(got.acked), 8'(want.acked));
                    check_field("bus_free", 8'(got.bus_free), 8'(want.bus_free));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                line_q.push_back(engine_tick(s_axis_tuser, s_axis_tdata[7:0],
                                             s_axis_tdata[8], s_axis_tdata[9]));
            tick_backlog = line_q.size();
        end
    end

endmodule

// ----- bench/tb_i2c_master_byte_engine.sv -----
// testbench top for the i2c master byte engine: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine;
    import i2cm_pkg::*;

    localparam logic [2:0] OP_SPARE_6     = 3'd6;
    localparam logic [2:0] OP_SPARE_7     = 3'd7;
    localparam int         TICK_TARGET    = 1350;
    localparam int         CALM_FROM      = 1150;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         PULSE_MAX      = int'(RECOVER_PULSES);

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;     // tx_byte[7:0], send_ack[8], sda_in[9], zero fill
    logic [2:0]  s_axis_tuser  = CMD_IDLE; // op[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // scl_out[0], sda_out[1], busy_res[2], rx_byte[10:3],
                                         // acked[11], bus_free[12], zero fill
    logic        m_axis_tlast;           // done_res

    int mismatch_count;
    int tick_backlog;
    int command_ticks = 0;
    int stall_left    = 0;
    int idle_cycles   = 0;
    bit calm          = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    i2c_master_byte_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    i2cm_line_checker line_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .tick_backlog   (tick_backlog)
    );

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 15);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_tick(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                             input logic sd);
        int gap;
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, sd, ack, tx};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // ignored while busy, so any code will do
    function automatic logic [2:0] stray_op();
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic logic [2:0] idle_op();
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0)
            return CMD_IDLE;
        else if (pick == 1)
            return OP_SPARE_6;
        else
            return OP_SPARE_7;
    endfunction

    task automatic idle_ticks(input int count);
        repeat (count)
            send_tick(idle_op(), 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // low_pct: chance that the bus reads low on each tick
    task automatic run_command(input logic [2:0] cmd, input logic [7:0] tx, input logic ack,
                               input int low_pct);
        int len;
        case (cmd)
            CMD_START: len = 4;
            CMD_STOP:  len = 3;
            CMD_WRITE: len = 27;
            default:   len = 21;
        endcase
        send_tick(cmd, tx, ack, $urandom_range(0, 99) >= low_pct);
        for (int i = 1; i < len; i++)
            send_tick(stray_op(), 8'($urandom), 1'($urandom), $urandom_range(0, 99) >= low_pct);
        command_ticks += len;
    endtask

    // bus low for min(lows, PULSE_MAX) pulse checks, then released if lows < PULSE_MAX
    task automatic run_recovery(input int lows);
        int pulses;
        pulses = (lows > PULSE_MAX) ? PULSE_MAX : lows;
        send_tick(CMD_RECOVER, 8'($urandom), 1'($urandom), 1'($urandom));
        repeat (pulses)
        begin
            send_tick(stray_op(), 8'($urandom), 1'($urandom), 1'b0);
            send_tick(stray_op(), 8'($urandom), 1'($urandom), 1'($urandom));
        end
        send_tick(stray_op(), 8'($urandom), 1'($urandom),
                  (lows >= PULSE_MAX) ? 1'($urandom) : 1'b1);
        repeat (3)
            send_tick(stray_op(), 8'($urandom), 1'($urandom), 1'($urandom));
        command_ticks += 5 + 2 * pulses;
    endtask

    task automatic run_transaction();
        int  nbytes;
        bit  reading;
        run_command(CMD_START, 8'($urandom), 1'($urandom), 50);
        run_command(CMD_WRITE, 8'($urandom), 1'($urandom), 50);
        nbytes  = $urandom_range(0, 3);
        reading = 1'($urandom);
        repeat (nbytes)
        begin
            if ($urandom_range(0, 5) == 0)
                idle_ticks($urandom_range(1, 2));
            if (reading)
                run_command(CMD_READ, 8'($urandom), 1'($urandom), $urandom_range(0, 100));
            else
                run_command(CMD_WRITE, 8'($urandom), 1'($urandom), 50);
        end
        // repeated start
        if ($urandom_range(0, 3) == 0)
        begin
            run_command(CMD_START, 8'($urandom), 1'($urandom), 50);
            run_command(CMD_WRITE, 8'($urandom), 1'($urandom), 50);
            run_command(CMD_READ, 8'($urandom), 1'($urandom), 50);
        end
        run_command(CMD_STOP, 8'($urandom), 1'($urandom), 50);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tick_backlog != 0);
    endtask

    initial
    begin
        int pick;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_tick(CMD_IDLE, 8'h00, 1'b0, 1'b0);
        send_tick(OP_SPARE_6, 8'hFF, 1'b1, 1'b1);
        send_tick(OP_SPARE_7, 8'h5A, 1'b0, 1'b1);
        run_command(CMD_START, 8'h00, 1'b0, 50);
        run_command(CMD_WRITE, 8'hFF, 1'b0, 100);
        run_command(CMD_WRITE, 8'h00, 1'b1, 0);
        run_command(CMD_READ, 8'h00, 1'b1, 0);
        run_command(CMD_READ, 8'hFF, 1'b0, 100);
        run_command(CMD_STOP, 8'h00, 1'b0, 50);
        run_command(CMD_STOP, 8'h00, 1'b0, 50);
        run_recovery(0);
        run_recovery(12);
        run_recovery(PULSE_MAX);
        run_recovery(4);
        run_command(CMD_START, 8'h00, 1'b0, 50);
        run_command(CMD_START, 8'h00, 1'b0, 50);
        run_command(CMD_READ, 8'hA5, 1'b1, 50);
        drain_results();

        // random
        while (command_ticks < TICK_TARGET)
        begin
            calm = (command_ticks >= CALM_FROM) || ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 7)
                run_transaction();
            else if (pick == 7)
                run_recovery($urandom_range(0, 12));
            else if (pick == 8)
                run_command(3'($urandom_range(1, 4)), 8'($urandom), 1'($urandom),
                            $urandom_range(0, 100));
            else
                idle_ticks($urandom_range(1, 4));
            if ($urandom_range(0, 15) == 0)
                drain_results();
        end

        s_axis_tvalid <= 1'b0;
        while (tick_backlog != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_step.sv
rtl/core/i2cm_out_stage.sv
rtl/core/i2c_master_byte_engine.sv
bench/i2cm_line_checker.sv
bench/tb_i2c_master_byte_engine.sv
